// ----- hdl/brb_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// brb_pkg: shared types and constants of the byte ring buffer
// Buffer geometry, status codes and the command word passed from the
// front end to the back end through the command queue.
// ----------------------------------------------------------------------------
package brb_pkg;

  // buffer geometry
  localparam int BUF_SIZE = 256;
  localparam int PTR_W    = $clog2(BUF_SIZE);
  localparam int MAX_READ = 64;

  // field widths
  localparam int BYTE_W   = 8;
  localparam int LEN_W    = 8;
  localparam int STAT_W   = 2;
  localparam int RLEN_W   = 7;

  // width for comparing pointer-sized values against byte lengths
  localparam int CMP_W    = (PTR_W > LEN_W) ? PTR_W : LEN_W;

  // command queue depth
  localparam int QUEUE_DEPTH = 4;
  localparam int QIDX_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // opcodes
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_READ  = 1'b1;

  // result status codes
  localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
  localparam logic [STAT_W-1:0] ST_NO_SPACE = 2'd1;
  localparam logic [STAT_W-1:0] ST_NO_DATA  = 2'd2;

  // classified command handed to the back end
  typedef struct packed {
    logic              is_read;
    logic [STAT_W-1:0] status;
    logic              store;
    logic [PTR_W-1:0]  addr;
    logic [BYTE_W-1:0] data;
    logic [RLEN_W-1:0] n;
  } cmd_t;

endpackage
`default_nettype wire

// ----- hdl/byte_ring_buffer_all_or_nothing.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// byte_ring_buffer_all_or_nothing: message byte ring buffer, top level
// Front end classifier, command queue and back end executor with store.
// ----------------------------------------------------------------------------
// Ring buffer of 256 bytes holding up to 255. A message is written as a run
// of write words, the first carrying the length; the message is stored only
// if it fits completely, otherwise every word of it answers no space, and
// readers see it only after its last byte. Each write word gives one result.
// A read word gives min(cap, stored, 64) results, or one no-data result.
// The input side takes one word per cycle as long as the four-entry command
// queue has room; the result side delivers one word per cycle unless stalled,
// so a read of n bytes holds the back end for n result words, one per byte
// via the single read port of the byte store. Input words keep flowing into
// the queue during a read run until it fills. No clearing pass after reset.
module byte_ring_buffer_all_or_nothing (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic                        in_opcode,
  input  wire logic                        in_first_of_message,
  input  wire logic [brb_pkg::LEN_W-1:0]   in_msg_len,
  input  wire logic [brb_pkg::BYTE_W-1:0]  in_data_in_byte,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [brb_pkg::STAT_W-1:0]       out_status,
  output logic [brb_pkg::BYTE_W-1:0]       out_data_byte,
  output logic                             out_last_of_run,
  output logic [brb_pkg::RLEN_W-1:0]       out_read_length
);

  brb_pkg::cmd_t front_cmd;
  brb_pkg::cmd_t head_cmd;
  logic          accept;
  logic          q_full;
  logic          q_empty;
  logic          pop;

  // accept a word whenever the queue has room
  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  brb_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .accept           (accept),
    .opcode           (in_opcode),
    .first_of_message (in_first_of_message),
    .msg_len          (in_msg_len),
    .data_in_byte     (in_data_in_byte),
    .cmd              (front_cmd)
  );

  brb_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (accept),
    .push_cmd (front_cmd),
    .pop      (pop),
    .head_cmd (head_cmd),
    .full     (q_full),
    .empty    (q_empty)
  );

  brb_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (head_cmd),
    .q_empty         (q_empty),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_data_byte   (out_data_byte),
    .out_last_of_run (out_last_of_run),
    .out_read_length (out_read_length)
  );

endmodule
`default_nettype wire

// ----- hdl/brb_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// brb_front: input classifier of the byte ring buffer
// Keeps the pointers and message state, decides per word whether it is
// stored, rejected or read, and emits one command per accepted word.
// ----------------------------------------------------------------------------
module brb_front (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       accept,
  input  wire logic                       opcode,
  input  wire logic                       first_of_message,
  input  wire logic [brb_pkg::LEN_W-1:0]  msg_len,
  input  wire logic [brb_pkg::BYTE_W-1:0] data_in_byte,
  output brb_pkg::cmd_t                   cmd
);

  logic [brb_pkg::PTR_W-1:0] ch_r, ch_nxt;
  logic [brb_pkg::PTR_W-1:0] rp_r, rp_nxt;
  logic [brb_pkg::PTR_W-1:0] wp_r, wp_nxt;
  logic [brb_pkg::LEN_W-1:0] left_r, left_nxt;
  logic                      acc_r, acc_nxt;

  logic [brb_pkg::PTR_W-1:0]  free_space;
  logic [brb_pkg::PTR_W-1:0]  stored;
  logic [brb_pkg::RLEN_W-1:0] cap;
  logic [brb_pkg::RLEN_W-1:0] n;
  logic [brb_pkg::PTR_W-1:0]  wp_eff;
  logic [brb_pkg::LEN_W-1:0]  left_eff;
  logic                       acc_eff;
  logic [brb_pkg::LEN_W-1:0]  left_dec;

  // occupancy figures from the committed pointers
  assign free_space = rp_r - ch_r - brb_pkg::PTR_W'(1);
  assign stored     = ch_r - rp_r;
  assign cap = (msg_len > brb_pkg::LEN_W'(brb_pkg::MAX_READ)) ?
               brb_pkg::RLEN_W'(brb_pkg::MAX_READ) : brb_pkg::RLEN_W'(msg_len);
  assign n   = (brb_pkg::CMP_W'(stored) < brb_pkg::CMP_W'(cap)) ?
               brb_pkg::RLEN_W'(stored) : cap;

  // message state as seen by this write word
  assign wp_eff   = first_of_message ? ch_r : wp_r;
  assign left_eff = first_of_message ? msg_len : left_r;
  assign acc_eff  = first_of_message ?
                    (brb_pkg::CMP_W'(free_space) >= brb_pkg::CMP_W'(msg_len)) : acc_r;
  assign left_dec = left_eff - brb_pkg::LEN_W'(1);

  // classify the word and work out the next pointer state
  always_comb begin
    ch_nxt   = ch_r;
    rp_nxt   = rp_r;
    wp_nxt   = wp_r;
    left_nxt = left_r;
    acc_nxt  = acc_r;
    cmd.is_read = 1'b0;
    cmd.status  = brb_pkg::ST_OK;
    cmd.store   = 1'b0;
    cmd.addr    = wp_eff;
    cmd.data    = data_in_byte;
    cmd.n       = n;
    if (opcode == brb_pkg::OP_READ) begin
      cmd.is_read = 1'b1;
      cmd.addr    = rp_r;
      rp_nxt      = rp_r + brb_pkg::PTR_W'(n);
    end else if (first_of_message && (msg_len == '0)) begin
      // empty message: acknowledged, nothing stored
      wp_nxt   = ch_r;
      left_nxt = '0;
      acc_nxt  = 1'b0;
    end else if (!first_of_message && (left_r == '0)) begin
      // stray word outside any message
      cmd.status = brb_pkg::ST_NO_SPACE;
    end else begin
      left_nxt = left_dec;
      if (acc_eff) begin
        cmd.store = 1'b1;
        wp_nxt    = wp_eff + brb_pkg::PTR_W'(1);
        acc_nxt   = 1'b1;
        if (left_dec == '0) begin
          ch_nxt  = wp_eff + brb_pkg::PTR_W'(1);
          acc_nxt = 1'b0;
        end
      end else begin
        cmd.status = brb_pkg::ST_NO_SPACE;
        wp_nxt     = wp_eff;
        acc_nxt    = 1'b0;
      end
    end
  end

  // pointer and message state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ch_r   <= '0;
      rp_r   <= '0;
      wp_r   <= '0;
      left_r <= '0;
      acc_r  <= 1'b0;
    end else if (accept) begin
      ch_r   <= ch_nxt;
      rp_r   <= rp_nxt;
      wp_r   <= wp_nxt;
      left_r <= left_nxt;
      acc_r  <= acc_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- hdl/brb_queue.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// brb_queue: command queue between front end and back end
// Small register FIFO of classified commands, written by the front end
// and drained in order by the back end.
// ----------------------------------------------------------------------------
module brb_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire brb_pkg::cmd_t push_cmd,
  input  wire logic          pop,
  output brb_pkg::cmd_t      head_cmd,
  output logic               full,
  output logic               empty
);

  brb_pkg::cmd_t              slot_r [brb_pkg::QUEUE_DEPTH];
  logic [brb_pkg::QIDX_W-1:0] wr_idx_r, rd_idx_r;
  logic [brb_pkg::QCNT_W-1:0] count_r;

  assign full     = (count_r == brb_pkg::QCNT_W'(brb_pkg::QUEUE_DEPTH));
  assign empty    = (count_r == '0);
  assign head_cmd = slot_r[rd_idx_r];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_idx_r] <= push_cmd;
    end
  end

  // indexes and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_idx_r <= '0;
      rd_idx_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_idx_r <= (wr_idx_r == brb_pkg::QIDX_W'(brb_pkg::QUEUE_DEPTH - 1)) ?
                    '0 : wr_idx_r + brb_pkg::QIDX_W'(1);
      end
      if (pop) begin
        rd_idx_r <= (rd_idx_r == brb_pkg::QIDX_W'(brb_pkg::QUEUE_DEPTH - 1)) ?
                    '0 : rd_idx_r + brb_pkg::QIDX_W'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + brb_pkg::QCNT_W'(1);
      end else if (pop && !push) begin
        count_r <= count_r - brb_pkg::QCNT_W'(1);
      end
    end
  end

endmodule
`default_nettype wire

// ----- hdl/brb_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// brb_back: executor of the byte ring buffer
// Owns the byte store, carries out queued commands in order and drives
// the registered result channel, one result word per cycle unless stalled.
// ----------------------------------------------------------------------------
module brb_back (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire brb_pkg::cmd_t               cmd,
  input  wire logic                        q_empty,
  output logic                             pop,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [brb_pkg::STAT_W-1:0]       out_status,
  output logic [brb_pkg::BYTE_W-1:0]       out_data_byte,
  output logic                             out_last_of_run,
  output logic [brb_pkg::RLEN_W-1:0]       out_read_length
);

  logic [brb_pkg::BYTE_W-1:0] byte_store [brb_pkg::BUF_SIZE];
  logic [brb_pkg::BYTE_W-1:0] rd_q;

  logic                       out_valid_r;
  logic [brb_pkg::STAT_W-1:0] out_status_r;
  logic                       out_last_r;
  logic [brb_pkg::RLEN_W-1:0] out_rlen_r;
  logic                       out_rd_r;

  logic                       busy_r, busy_nxt;
  logic [brb_pkg::PTR_W-1:0]  raddr_r, raddr_nxt;
  logic [brb_pkg::RLEN_W-1:0] cnt_r, cnt_nxt;
  logic [brb_pkg::RLEN_W-1:0] n_r, n_nxt;

  logic                       adv;
  logic                       emit;
  logic                       rd_en;
  logic [brb_pkg::PTR_W-1:0]  ra;
  logic                       we;
  logic [brb_pkg::STAT_W-1:0] st;
  logic                       last;
  logic [brb_pkg::RLEN_W-1:0] rlen;
  logic                       isrd;

  // output register free or being emptied this cycle
  assign adv = !out_valid_r || !out_stall;

  // sequencer: continue a read run or start the next command
  always_comb begin
    pop       = 1'b0;
    emit      = 1'b0;
    rd_en     = 1'b0;
    ra        = raddr_r;
    we        = 1'b0;
    st        = brb_pkg::ST_OK;
    last      = 1'b1;
    rlen      = '0;
    isrd      = 1'b0;
    busy_nxt  = busy_r;
    raddr_nxt = raddr_r;
    cnt_nxt   = cnt_r;
    n_nxt     = n_r;
    if (adv) begin
      if (busy_r) begin
        emit      = 1'b1;
        isrd      = 1'b1;
        rd_en     = 1'b1;
        last      = (cnt_r == brb_pkg::RLEN_W'(1));
        rlen      = n_r;
        raddr_nxt = raddr_r + brb_pkg::PTR_W'(1);
        cnt_nxt   = cnt_r - brb_pkg::RLEN_W'(1);
        busy_nxt  = (cnt_r != brb_pkg::RLEN_W'(1));
      end else if (!q_empty) begin
        pop  = 1'b1;
        emit = 1'b1;
        if (cmd.is_read) begin
          if (cmd.n == '0) begin
            st = brb_pkg::ST_NO_DATA;
          end else begin
            isrd      = 1'b1;
            rd_en     = 1'b1;
            ra        = cmd.addr;
            last      = (cmd.n == brb_pkg::RLEN_W'(1));
            rlen      = cmd.n;
            raddr_nxt = cmd.addr + brb_pkg::PTR_W'(1);
            cnt_nxt   = cmd.n - brb_pkg::RLEN_W'(1);
            n_nxt     = cmd.n;
            busy_nxt  = (cmd.n != brb_pkg::RLEN_W'(1));
          end
        end else begin
          st = cmd.status;
          we = cmd.store;
        end
      end
    end
  end

  // byte store, registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      byte_store[cmd.addr] <= cmd.data;
    end
    if (rd_en) begin
      rd_q <= byte_store[ra];
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      busy_r      <= 1'b0;
    end else if (adv) begin
      out_valid_r <= emit;
      busy_r      <= busy_nxt;
    end
  end

  // result payload and run counters
  always_ff @(posedge clk) begin
    if (adv) begin
      out_status_r <= st;
      out_last_r   <= last;
      out_rlen_r   <= rlen;
      out_rd_r     <= isrd;
      raddr_r      <= raddr_nxt;
      cnt_r        <= cnt_nxt;
      n_r          <= n_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_data_byte   = out_rd_r ? rd_q : '0;
  assign out_last_of_run = out_last_r;
  assign out_read_length = out_rlen_r;

endmodule
`default_nettype wire

// ----- sim/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: byte ring buffer with all-or-nothing message writes
// Directed and random traffic drives the write and read word stream. A local
// ring model predicts every result word, and a checker process compares each
// delivered word field by field while both sides pause and stall at random.
// ----------------------------------------------------------------------------
module testbench;
  import brb_pkg::*;

  localparam int RANDOM_WORDS  = 360;
  localparam int SETTLE_CYCLES = 20;

  typedef logic [PTR_W-1:0] ptr_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [BYTE_W-1:0] data;
    logic              last;
    logic [RLEN_W-1:0] rlen;
  } ring_result_t;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  logic              in_opcode;
  logic              in_first_of_message;
  logic [LEN_W-1:0]  in_msg_len;
  logic [BYTE_W-1:0] in_data_in_byte;
  logic              out_valid;
  logic              out_stall;
  logic [STAT_W-1:0] out_status;
  logic [BYTE_W-1:0] out_data_byte;
  logic              out_last_of_run;
  logic [RLEN_W-1:0] out_read_length;

  // ring model state
  logic [BYTE_W-1:0] ring_bytes [BUF_SIZE];
  ptr_t              pub_head;
  ptr_t              tail_ptr;
  ptr_t              fill_ptr;
  logic [LEN_W-1:0]  msg_remaining;
  logic              msg_storing;

  ring_result_t expected_results [$];
  int           mismatch_count = 0;
  int           words_sent = 0;
  bit           calm = 1'b0;

  // clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  byte_ring_buffer_all_or_nothing uut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_opcode           (in_opcode),
    .in_first_of_message (in_first_of_message),
    .in_msg_len          (in_msg_len),
    .in_data_in_byte     (in_data_in_byte),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_status          (out_status),
    .out_data_byte       (out_data_byte),
    .out_last_of_run     (out_last_of_run),
    .out_read_length     (out_read_length)
  );

  // idle cycles before a word, none during calm stretches
  function automatic int draw_gap();
    if (calm) return 0;
    return ($urandom_range(0, 2) == 0) ? int'($urandom_range(1, 12)) : 0;
  endfunction

  function automatic void push_result(logic [STAT_W-1:0] status, logic [BYTE_W-1:0] data,
                                      logic last, logic [RLEN_W-1:0] rlen);
    ring_result_t r;
    r.status = status;
    r.data   = data;
    r.last   = last;
    r.rlen   = rlen;
    expected_results.push_back(r);
  endfunction

  // predict the result words of one accepted word and update the ring model
  function automatic void predict_ring_word(logic op, logic first, logic [LEN_W-1:0] len,
                                            logic [BYTE_W-1:0] data);
    ptr_t free_space;
    ptr_t stored;
    int   cap;
    int   n;
    if (op == OP_READ) begin
      stored = pub_head - tail_ptr;
      cap = (int'(len) > MAX_READ) ? MAX_READ : int'(len);
      n = (cap < int'(stored)) ? cap : int'(stored);
      if (n == 0) begin
        push_result(ST_NO_DATA, '0, 1'b1, '0);
      end else begin
        for (int i = 0; i < n; i++) begin
          push_result(ST_OK, ring_bytes[tail_ptr], (i == n - 1), RLEN_W'(n));
          tail_ptr = tail_ptr + 1'b1;
        end
      end
      return;
    end
    // write word: space is checked once, at the first byte
    if (first) begin
      free_space    = tail_ptr - pub_head - 1'b1;
      fill_ptr      = pub_head;
      msg_remaining = len;
      msg_storing   = (free_space >= len);
      if (len == '0) begin
        msg_storing = 1'b0;
        push_result(ST_OK, '0, 1'b1, '0);
        return;
      end
    end else if (msg_remaining == '0) begin
      push_result(ST_NO_SPACE, '0, 1'b1, '0);
      return;
    end
    msg_remaining = msg_remaining - 1'b1;
    if (msg_storing) begin
      ring_bytes[fill_ptr] = data;
      fill_ptr = fill_ptr + 1'b1;
      if (msg_remaining == '0) begin
        pub_head    = fill_ptr;
        msg_storing = 1'b0;
      end
      push_result(ST_OK, '0, 1'b1, '0);
    end else begin
      if (msg_remaining == '0) msg_storing = 1'b0;
      push_result(ST_NO_SPACE, '0, 1'b1, '0);
    end
  endfunction

  // send one word; called and returning at a falling edge
  task automatic send_word(logic op, logic first, logic [LEN_W-1:0] len,
                           logic [BYTE_W-1:0] data);
    int gap;
    gap = draw_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid            <= 1'b1;
    in_opcode           <= op;
    in_first_of_message <= first;
    in_msg_len          <= len;
    in_data_in_byte     <= data;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_ring_word(op, first, len, data);
    words_sent++;
    @(negedge clk);
  endtask

  task automatic send_write(logic first, logic [LEN_W-1:0] len, logic [BYTE_W-1:0] data);
    send_word(OP_WRITE, first, len, data);
  endtask

  // unused fields of a read carry random values
  task automatic send_read(logic [LEN_W-1:0] cap);
    send_word(OP_READ, 1'($urandom), cap, 8'($urandom));
  endtask

  // complete message of random bytes
  task automatic send_message(int len);
    send_write(1'b1, LEN_W'(len), 8'($urandom));
    for (int k = 1; k < len; k++) send_write(1'b0, 8'($urandom), 8'($urandom));
  endtask

  task automatic report_field(string what, int unsigned want, int unsigned got);
    if (want != got) begin
      mismatch_count++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
    end
  endtask

  // result side: random stall per word, check each accepted word
  initial begin : result_checker
    ring_result_t got;
    ring_result_t want;
    int           gap;
    out_stall = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      gap = draw_gap();
      if (gap != 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(negedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      got = {out_status, out_data_byte, out_last_of_run, out_read_length};
      // compare after the edge so the prediction of this edge is queued
      @(negedge clk);
      if (expected_results.size() == 0) begin
        mismatch_count++;
        $display("%0t: result word with none expected, status %0d data %0d last %0d len %0d",
                 $time, got.status, got.data, got.last, got.rlen);
      end else begin
        want = expected_results.pop_front();
        report_field("status", want.status, got.status);
        report_field("data", want.data, got.data);
        report_field("last", want.last, got.last);
        report_field("read length", want.rlen, got.rlen);
      end
    end
  end

  // reads of an empty buffer, with zero and oversized caps
  task automatic test_empty_reads();
    send_read(8'd0);
    send_read(8'd255);
  endtask

  // whole messages become visible, partial reads and a zero cap
  task automatic test_commit_and_read();
    send_write(1'b1, 8'd1, 8'hFF);
    send_write(1'b1, 8'd3, 8'h00);
    send_write(1'b0, 8'd0, 8'hA5);
    send_write(1'b0, 8'hFF, 8'h5A);
    send_read(8'd0);
    send_read(8'd2);
  endtask

  // empty message and a byte outside any message
  task automatic test_zero_length_and_stray();
    send_write(1'b1, 8'd0, 8'h3C);
    send_write(1'b0, 8'd7, 8'hC3);
  endtask

  // reader must not see bytes of the message in flight
  task automatic test_read_during_write();
    send_write(1'b1, 8'd2, 8'h11);
    send_read(8'd255);
    send_write(1'b0, 8'd0, 8'h22);
    send_read(8'd1);
  endtask

  // new first byte drops the unfinished message
  task automatic test_abandoned_message();
    send_write(1'b1, 8'd4, 8'h77);
    send_write(1'b0, 8'd0, 8'h88);
    send_write(1'b1, 8'd1, 8'h99);
    send_read(8'd64);
  endtask

  // message larger than the free space is refused byte by byte
  task automatic test_rejected_message();
    send_write(1'b1, 8'd1, 8'h01);
    send_write(1'b1, 8'd255, 8'hF0);
    send_write(1'b0, 8'd0, 8'h0F);
    send_write(1'b0, 8'd0, 8'hAA);
    send_read(8'd255);
  endtask

  // mostly well-formed messages and reads, in fill and drain phases
  task automatic test_random_traffic();
    int stop_at;
    int phase_left;
    int pick;
    int len;
    int cut;
    bit filling;
    stop_at    = words_sent + RANDOM_WORDS;
    phase_left = 0;
    filling    = 1'b1;
    while (words_sent < stop_at) begin
      if (phase_left == 0) begin
        phase_left = $urandom_range(10, 40);
        filling    = $urandom_range(0, 1);
        calm       = ($urandom_range(0, 3) == 0);
      end
      phase_left--;
      pick = $urandom_range(0, 99);
      if (pick < (filling ? 75 : 40)) begin
        case ($urandom_range(0, 19))
          0:       len = 0;
          1, 2:    len = $urandom_range(13, 100);
          default: len = $urandom_range(1, 12);
        endcase
        if (len == 0) send_write(1'b1, 8'd0, 8'($urandom));
        else send_message(len);
      end else if (pick < 90) begin
        if ($urandom_range(0, 4) == 0) send_read(8'($urandom_range(65, 255)));
        else send_read(8'($urandom_range(0, 64)));
      end else if (pick < 96) begin
        // broken message: cut short before its last byte
        len = $urandom_range(2, 255);
        cut = $urandom_range(1, (len - 1 < 12) ? len - 1 : 12);
        send_write(1'b1, LEN_W'(len), 8'($urandom));
        for (int k = 1; k < cut; k++) send_write(1'b0, 8'($urandom), 8'($urandom));
      end else begin
        send_word(1'($urandom), 1'($urandom), 8'($urandom), 8'($urandom));
      end
    end
    calm = 1'b0;
  endtask

  initial begin : run_tests
    rst_n               = 1'b0;
    in_valid            = 1'b0;
    in_opcode           = OP_WRITE;
    in_first_of_message = 1'b0;
    in_msg_len          = '0;
    in_data_in_byte     = '0;
    pub_head            = '0;
    tail_ptr            = '0;
    fill_ptr            = '0;
    msg_remaining       = '0;
    msg_storing         = 1'b0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    test_empty_reads();
    test_commit_and_read();
    test_zero_length_and_stray();
    test_read_during_write();
    test_abandoned_message();
    test_rejected_message();
    test_random_traffic();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

  // run limit
  initial begin : watchdog
    #18_000_000;
    $display("testbench failed");
    $finish;
  end

endmodule

// ----- files.f -----
hdl/brb_pkg.sv
hdl/brb_front.sv
hdl/brb_queue.sv
hdl/brb_back.sv
hdl/byte_ring_buffer_all_or_nothing.sv
sim/testbench.sv
